// File: sv/softened_gravity_accumulator_macros.svh
// Assertion helpers used by the back-end RTL
`ifndef SOFTENED_GRAVITY_ACCUMULATOR_MACROS_SVH
`define SOFTENED_GRAVITY_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define SGA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sga_pkg.sv
package sga_pkg;

  localparam int QueueDepth = 2;

  localparam logic [1:0] CFG_GRAV  = 2'd0;
  localparam logic [1:0] CFG_SOFT  = 2'd1;
  localparam logic [1:0] CFG_UNITM = 2'd2;

  localparam logic [31:0] GRAV_RESET = 32'd65536;
  localparam logic [31:0] MASS_ONE   = 32'd65536;

  typedef struct packed {
    logic signed [31:0] tgt_pos_x;
    logic signed [31:0] tgt_pos_y;
    logic signed [31:0] tgt_pos_z;
    logic [15:0]        tgt_id;
    logic signed [31:0] src_pos_x;
    logic signed [31:0] src_pos_y;
    logic signed [31:0] src_pos_z;
    logic [31:0]        src_mass;
    logic [15:0]        src_count;
    logic [15:0]        src_id;
    logic               last_item;
  } sga_in_t;

  typedef struct packed {
    logic signed [47:0] acc_x;
    logic signed [47:0] acc_y;
    logic signed [47:0] acc_z;
  } sga_out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        use_src;
    logic        last;
    logic [2:0]  neg;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [32:0] mag_z;
    logic [31:0] mass;
  } sga_job_t;

endpackage

// File: sv/sga_front.sv
module sga_front import sga_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  sga_in_t  in_data,
  output logic     in_full,
  input  logic     one_mass_en,
  output logic     job_valid,
  output sga_job_t job,
  input  logic     job_full
);

  logic     valid_r;
  sga_job_t job_r;
  sga_job_t job_nxt;
  logic     take;
  logic signed [32:0] dx, dy, dz;

  assign in_full   = valid_r && job_full;
  assign take      = in_push && !in_full;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    dx = 33'(in_data.src_pos_x) - 33'(in_data.tgt_pos_x);
    dy = 33'(in_data.src_pos_y) - 33'(in_data.tgt_pos_y);
    dz = 33'(in_data.src_pos_z) - 33'(in_data.tgt_pos_z);
    job_nxt.neg   = {dz[32], dy[32], dx[32]};
    job_nxt.mag_x = dx[32] ? 33'(-dx) : 33'(dx);
    job_nxt.mag_y = dy[32] ? 33'(-dy) : 33'(dy);
    job_nxt.mag_z = dz[32] ? 33'(-dz) : 33'(dz);
    job_nxt.last  = in_data.last_item;
    // mark empty, self and coincident sources as unused
    job_nxt.use_src = (in_data.src_count != 16'd0) &&
                      !(in_data.src_count == 16'd1 && in_data.src_id == in_data.tgt_id) &&
                      (dx != 33'sd0 || dy != 33'sd0 || dz != 33'sd0);
    job_nxt.mass = (in_data.src_count == 16'd1 && one_mass_en) ? MASS_ONE : in_data.src_mass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!job_full) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: sv/sga_queue.sv
module sga_queue import sga_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sga_job_t wdata,
  output logic     full,
  input  logic     pop,
  output sga_job_t rdata,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sga_job_t        mem [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

// File: sv/sga_back.sv
module sga_back import sga_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] grav_const,
  input  logic [31:0] softening_len,
  input  logic        job_empty,
  input  sga_job_t    job,
  output logic        job_pop,
  output logic        out_empty,
  output sga_out_t    out_data,
  input  logic        out_pop
);

`include "softened_gravity_accumulator_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DEN  = 3'd3;
  localparam logic [2:0] ST_NUM  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam logic [5:0] MUL_LAST  = 6'd4;
  localparam logic [5:0] SQRT_LAST = 6'd33;
  localparam logic [5:0] DIV_LAST  = 6'd48;

  localparam logic [47:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] CAP_NEG = 48'h8000_0000_0000;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   cnt_r;
  logic [1:0]   comp_r;
  sga_job_t     job_r;
  logic [65:0]  s_r;
  logic [67:0]  d_r;
  logic [63:0]  gm_r;
  logic [67:0]  rad_r;
  logic [35:0]  srem_r;
  logic [33:0]  root_r;
  logic [99:0]  den_r;
  logic [96:0]  num_r;
  logic [120:0] rem_r;
  logic [147:0] dv_r;
  logic [48:0]  q_r;
  logic signed [47:0] sum_r [3];
  logic         out_valid_r;
  sga_out_t     out_r;

  logic [33:0]  mul_a, mul_b;
  logic [67:0]  prod;
  logic [32:0]  mag_sel;
  logic         neg_sel;
  logic [37:0]  sq_rem;
  logic [35:0]  sq_trial;
  logic         sq_ge;
  logic         dv_ge;
  logic [47:0]  cap, mag;
  logic signed [48:0] contrib;
  logic signed [49:0] sum_wide;
  logic signed [47:0] sum_sat;
  logic         load_out;

  assign job_pop   = (state_r == ST_IDLE) && !job_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign load_out  = (state_r == ST_FIN) && job_r.last && (!out_valid_r || out_pop);

  always_comb begin
    case (comp_r)
      2'd0:    begin mag_sel = job_r.mag_x; neg_sel = job_r.neg[0]; end
      2'd1:    begin mag_sel = job_r.mag_y; neg_sel = job_r.neg[1]; end
      default: begin mag_sel = job_r.mag_z; neg_sel = job_r.neg[2]; end
    endcase
  end

  // one shared 34x34 multiplier, operands steered by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        case (cnt_r)
          6'd0:    begin mul_a = {1'b0, job_r.mag_x}; mul_b = {1'b0, job_r.mag_x}; end
          6'd1:    begin mul_a = {1'b0, job_r.mag_y}; mul_b = {1'b0, job_r.mag_y}; end
          6'd2:    begin mul_a = {1'b0, job_r.mag_z}; mul_b = {1'b0, job_r.mag_z}; end
          6'd3:    begin mul_a = {2'b0, softening_len}; mul_b = {2'b0, softening_len}; end
          default: begin mul_a = {2'b0, grav_const}; mul_b = {2'b0, job_r.mass}; end
        endcase
      end
      ST_DEN: begin
        mul_a = (cnt_r == 6'd0) ? d_r[33:0] : d_r[67:34];
        mul_b = root_r;
      end
      ST_NUM: begin
        mul_a = (cnt_r == 6'd0) ? {2'b0, gm_r[31:0]} : {2'b0, gm_r[63:32]};
        mul_b = {1'b0, mag_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    sq_rem   = {srem_r, rad_r[67:66]};
    sq_trial = {root_r, 2'b01};
    sq_ge    = (sq_rem >= 38'(sq_trial));
    dv_ge    = ({27'b0, rem_r} >= dv_r);
    cap      = neg_sel ? CAP_NEG : CAP_POS;
    mag      = (q_r[48] || q_r[47:0] > cap) ? cap : q_r[47:0];
    contrib  = neg_sel ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sum_wide = 50'(sum_r[comp_r]) + 50'(contrib);
    if (sum_wide > 50'sh7FFF_FFFF_FFFF) begin
      sum_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (sum_wide < -50'sh8000_0000_0000) begin
      sum_sat = 48'sh8000_0000_0000;
    end else begin
      sum_sat = sum_wide[47:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!job_empty) state_nxt = job.use_src ? ST_MUL : ST_FIN;
      ST_MUL:  if (cnt_r == MUL_LAST) state_nxt = ST_SQRT;
      ST_SQRT: if (cnt_r == SQRT_LAST) state_nxt = ST_DEN;
      ST_DEN:  if (cnt_r == 6'd1) state_nxt = ST_NUM;
      ST_NUM:  if (cnt_r == 6'd1) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DIV_LAST) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (comp_r == 2'd2) ? ST_FIN : ST_NUM;
      ST_FIN:  if (!job_r.last || load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: comp_r <= '0;
        ST_ACC: begin
          sum_r[comp_r] <= sum_sat;
          comp_r        <= comp_r + 2'd1;
        end
        ST_FIN: begin
          if (load_out) begin
            sum_r[0] <= '0;
            sum_r[1] <= '0;
            sum_r[2] <= '0;
          end
        end
        default: comp_r <= comp_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (!job_empty) job_r <= job;
      end
      ST_MUL: begin
        case (cnt_r)
          6'd0:    s_r  <= prod[65:0];
          6'd1:    s_r  <= s_r + prod[65:0];
          6'd2:    s_r  <= s_r + prod[65:0];
          6'd3:    d_r  <= 68'(s_r) + prod;
          default: gm_r <= prod[63:0];
        endcase
        rad_r  <= {2'b0, s_r};
        srem_r <= '0;
        root_r <= '0;
      end
      ST_SQRT: begin
        // two radicand bits per step, one root bit out
        if (sq_ge) begin
          srem_r <= 36'(sq_rem - 38'(sq_trial));
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          srem_r <= sq_rem[35:0];
          root_r <= {root_r[32:0], 1'b0};
        end
        rad_r <= {rad_r[65:0], 2'b0};
      end
      ST_DEN: begin
        if (cnt_r == 6'd0) begin
          den_r <= 100'(prod);
        end else begin
          den_r <= den_r + {prod[65:0], 34'b0};
        end
      end
      ST_NUM: begin
        if (cnt_r == 6'd0) begin
          num_r <= 97'(prod);
        end else begin
          num_r <= num_r + {prod[64:0], 32'b0};
          rem_r <= '0;
        end
        q_r  <= '0;
        dv_r <= {den_r, 48'b0};
      end
      ST_DIV: begin
        // restoring division; the first step flags a quotient past 48 bits
        if (cnt_r == 6'd0) begin
          if ({27'b0, num_r, 24'b0} >= dv_r) begin
            rem_r <= {num_r, 24'b0} - dv_r[120:0];
            q_r   <= 49'd1;
          end else begin
            rem_r <= {num_r, 24'b0};
            q_r   <= 49'd0;
          end
        end else if (dv_ge) begin
          rem_r <= rem_r - dv_r[120:0];
          q_r   <= {q_r[47:0], 1'b1};
        end else begin
          q_r   <= {q_r[47:0], 1'b0};
        end
        dv_r <= {1'b0, dv_r[147:1]};
      end
      ST_FIN: begin
        if (load_out) begin
          out_r.acc_x <= sum_r[0];
          out_r.acc_y <= sum_r[1];
          out_r.acc_z <= sum_r[2];
        end
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  `SGA_ASSERT_IMP(a_root_floor, (state_r == ST_DEN && cnt_r == 6'd0), (68'(root_r) * 68'(root_r) <= 68'(s_r)), "square root above radicand")
  `SGA_ASSERT_IMP(a_den_nonzero, (state_r == ST_NUM && cnt_r == 6'd0), (den_r != '0), "zero divisor for a used source")
  `SGA_ASSERT_NXT(a_out_load, load_out, (out_valid_r && sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0), "result not loaded or sum not cleared")
  `SGA_ASSERT_IMP(a_no_pop_busy, job_pop, (state_r == ST_IDLE), "queue popped while busy")

endmodule

// File: sv/softened_gravity_accumulator.sv
// A used source holds the back end through the pop, the multiplies (three squares, eps
// squared, G times mass), the root steps, the divisor products, per axis the numerator
// products, divide steps and an add, then the finish, which for a last word waits for a
// free output; a skipped source holds it only for the pop and the finish. A word passes the
// front register and the queue first. A new source starts only once the last is through.
// Reset (rst_n low, synchronous) empties queue and output, clears sums, G = 1.0, eps = 0.
module softened_gravity_accumulator import sga_pkg::*; #(
  parameter int QDEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word channel
  input  logic        in_push,
  input  sga_in_t     in_data,
  output logic        in_full,
  // result word channel
  output logic        out_empty,
  output sga_out_t    out_data,
  input  logic        out_pop,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] grav_const_r;
  logic [31:0] softening_len_r;
  logic        one_mass_r;

  logic        job_valid, job_full, job_empty, job_pop;
  sga_job_t    job_in, job_out;

  // configuration: always ready, unknown index dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_const_r    <= GRAV_RESET;
      softening_len_r <= '0;
      one_mass_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRAV:  grav_const_r    <= cfg_data;
        CFG_SOFT:  softening_len_r <= cfg_data;
        CFG_UNITM: one_mass_r      <= cfg_data[0];
        default:   one_mass_r      <= one_mass_r;
      endcase
    end
  end

  // front: take the word, form the separation, classify skip or use
  sga_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .one_mass_en (one_mass_r),
    .job_valid   (job_valid),
    .job         (job_in),
    .job_full    (job_full)
  );

  // short queue decouples front from the slow back end
  sga_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // back: force evaluation, saturating accumulate, result hold
  sga_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .grav_const    (grav_const_r),
    .softening_len (softening_len_r),
    .job_empty     (job_empty),
    .job           (job_out),
    .job_pop       (job_pop),
    .out_empty     (out_empty),
    .out_data      (out_data),
    .out_pop       (out_pop)
  );

endmodule

// File: test/tb_softened_gravity_accumulator.sv
`timescale 1ns / 1ps

module tb_softened_gravity_accumulator;
  import sga_pkg::*;

  // Index that maps to no register; the block must leave every setting alone.
  localparam logic [1:0] CfgUnused = 2'd3;
  // Cycles to let the back end finish the sources still held in front, queue and back.
  localparam int SettleCycles = 1000;
  // Cycles without any handshake before the run is declared hung.
  localparam int HangLimit = 20000;
  localparam logic signed [48:0] AccMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] AccMin = -49'sh0_8000_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  sga_in_t     in_data = '0;
  logic        in_full;
  logic        out_empty;
  sga_out_t    out_data;
  logic        out_pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  softened_gravity_accumulator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block: registers and running sums.
  logic [31:0]        grav_q16;
  logic [31:0]        eps_q16;
  logic               one_mass_on;
  logic signed [47:0] net_acc [3];
  sga_out_t           pending_acc [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int quiet_cycles = 0;

  // Integer square root of a Q32.32 square, giving a Q16.16 distance.
  function automatic logic [63:0] dist_root(logic [127:0] sq);
    logic [63:0]  root;
    logic [63:0]  cand;
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= sq) root = cand;
    end
    return root;
  endfunction

  // One axis of G*m*r_i/(D*|r|), rounded down in magnitude and capped per sign.
  function automatic logic signed [48:0] axis_pull(logic signed [32:0] d, logic [63:0] gm,
                                                   logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] cap;
    mag = d < 0 ? 128'(-d) : 128'(d);
    num = ({64'd0, gm} * mag) << 24;
    quo = num / den;
    cap = d < 0 ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (quo > cap) quo = cap;
    return d < 0 ? -$signed(49'(quo)) : $signed(49'(quo));
  endfunction

  // Fold one source into the sums; hand back the sums when it closes the list.
  task automatic fold_source(input sga_in_t w);
    logic signed [32:0] d [3];
    logic [127:0]       sq;
    logic [127:0]       den;
    logic [63:0]        root;
    logic [63:0]        gm;
    logic [31:0]        mass;
    logic signed [48:0] acc;
    sga_out_t           res;
    bit                 used;
    used = w.src_count != 0 && !(w.src_count == 1 && w.src_id == w.tgt_id);
    d[0] = 33'(w.src_pos_x) - 33'(w.tgt_pos_x);
    d[1] = 33'(w.src_pos_y) - 33'(w.tgt_pos_y);
    d[2] = 33'(w.src_pos_z) - 33'(w.tgt_pos_z);
    // a coincident source adds nothing, whatever the softening
    if (used && (d[0] != 0 || d[1] != 0 || d[2] != 0)) begin
      sq = '0;
      for (int i = 0; i < 3; i++) sq += 128'(d[i] < 0 ? -d[i] : d[i]) ** 2;
      root = dist_root(sq);
      den  = (sq + {96'd0, eps_q16} * {96'd0, eps_q16}) * {64'd0, root};
      mass = (w.src_count == 1 && one_mass_on) ? MASS_ONE : w.src_mass;
      gm   = {32'd0, grav_q16} * {32'd0, mass};
      for (int i = 0; i < 3; i++) begin
        acc = 49'(net_acc[i]) + axis_pull(d[i], gm, den);
        if (acc > AccMax) acc = AccMax;
        if (acc < AccMin) acc = AccMin;
        net_acc[i] = acc[47:0];
      end
    end
    if (w.last_item) begin
      res.acc_x = net_acc[0];
      res.acc_y = net_acc[1];
      res.acc_z = net_acc[2];
      pending_acc.push_back(res);
      for (int i = 0; i < 3; i++) net_acc[i] = '0;
    end
  endtask

  // Offer one word and hold it until the block takes it, then idle at random.
  task automatic send_word(input sga_in_t w);
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    fold_source(w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending, wait for every result, then let the back end go quiet.
  task automatic settle();
    in_push <= 1'b0;
    while (pending_acc.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRAV:  grav_q16 = val;
      CFG_SOFT:  eps_q16 = val;
      CFG_UNITM: one_mass_on = val[0];
      default: ;
    endcase
  endtask

  function automatic sga_in_t body_at(logic [31:0] tx, logic [31:0] sx, logic [31:0] sy,
                                      logic [31:0] sz, logic [15:0] cnt, bit last);
    sga_in_t w;
    w = '0;
    w.tgt_pos_x = tx;
    w.tgt_id    = 16'd7;
    w.src_pos_x = sx;
    w.src_pos_y = sy;
    w.src_pos_z = sz;
    w.src_mass  = 32'h0001_0000;
    w.src_count = cnt;
    w.src_id    = 16'd9;
    w.last_item = last;
    return w;
  endfunction

  task automatic test_directed();
    sga_in_t w;
    // unit distance on the x and y axes, then diagonal, each closed on its own
    send_word(body_at(0, 32'h0001_0000, 0, 0, 1, 1));
    send_word(body_at(0, 0, 32'hFFFF_0000, 0, 1, 1));
    send_word(body_at(0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 3, 1));
    // empty source, self source, coincident source, and a skipped last item
    send_word(body_at(0, 32'h0001_0000, 0, 0, 0, 0));
    w = body_at(0, 32'h0001_0000, 0, 0, 1, 0);
    w.src_id = w.tgt_id;
    send_word(w);
    send_word(body_at(32'h0005_0000, 32'h0005_0000, 0, 0, 1, 0));
    send_word(body_at(0, 0, 32'h0003_0000, 0, 0, 1));
    // extreme separations: full span positive and negative
    send_word(body_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 2, 1));
    send_word(body_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1));
    // smallest step with the heaviest mass: saturate one contribution and the sum
    w = body_at(0, 32'd1, 0, 0, 2, 0);
    w.src_mass = 32'hFFFF_FFFF;
    send_word(w);
    send_word(w);
    w.src_pos_x = 32'hFFFF_FFFF;
    w.last_item = 1'b1;
    send_word(w);
    w.src_pos_x = 32'hFFFF_FFFF;
    w.src_pos_y = 32'hFFFF_FFFF;
    w.src_pos_z = 32'hFFFF_FFFF;
    send_word(w);
    settle();
    // unit mass only alters single bodies; aggregates keep their mass
    write_reg(CFG_UNITM, 32'd1);
    write_reg(CFG_SOFT, 32'h0000_8000);
    w = body_at(0, 32'h0002_0000, 32'h0001_0000, 0, 1, 1);
    w.src_mass = 32'h0123_4567;
    send_word(w);
    w.src_count = 16'd2;
    send_word(w);
    w.src_mass = 32'd0;
    send_word(w);
    settle();
    // a large softening applies at the smallest separation; an unused index changes nothing
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    write_reg(CFG_SOFT, 32'hFFFF_FFFF);
    write_reg(CFG_GRAV, 32'hFFFF_FFFF);
    send_word(body_at(0, 32'd1, 0, 0, 1, 1));
    settle();
    write_reg(CFG_GRAV, 32'd0);
    send_word(body_at(0, 32'h0001_0000, 0, 0, 1, 1));
    settle();
  endtask

  // Random source around a target: mostly near, sometimes anywhere, sometimes on top or one step above.
  function automatic sga_in_t random_source(sga_in_t tgt);
    sga_in_t w;
    int      pick;
    w = tgt;
    pick = $urandom_range(99);
    w.src_pos_x = tgt.tgt_pos_x + $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    w.src_pos_y = tgt.tgt_pos_y + $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    w.src_pos_z = tgt.tgt_pos_z + $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    if (pick < 15) begin
      w.src_pos_x = $urandom();
      w.src_pos_y = $urandom();
      w.src_pos_z = $urandom();
    end else if (pick < 20) begin
      w.src_pos_x = tgt.tgt_pos_x;
      w.src_pos_y = tgt.tgt_pos_y;
      w.src_pos_z = tgt.tgt_pos_z + ($urandom_range(1) ? 32'sd0 : 32'sd1);
    end
    w.src_mass = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0010_0000);
    case ($urandom_range(9))
      0:       w.src_count = 16'd0;
      1, 2, 3, 4, 5: w.src_count = 16'd1;
      default: w.src_count = 16'($urandom_range(16'hFFFF, 2));
    endcase
    w.src_id = $urandom_range(7) == 0 ? tgt.tgt_id : 16'($urandom());
    w.last_item = $urandom_range(7) == 0;
    return w;
  endfunction

  // Streams of sources per target, with a fresh target after each closed list.
  task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
    sga_in_t tgt;
    sga_in_t w;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    tgt = '0;
    for (int k = 0; k < n_words; k++) begin
      if (k == 0 || w.last_item) begin
        tgt.tgt_pos_x = $urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF);
        tgt.tgt_pos_y = $urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF);
        tgt.tgt_pos_z = $urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF);
        tgt.tgt_id    = 16'($urandom());
      end
      w = random_source(tgt);
      send_word(w);
    end
    settle();
  endtask

  initial begin
    grav_q16    = GRAV_RESET;
    eps_q16     = '0;
    one_mass_on = 1'b0;
    for (int i = 0; i < 3; i++) net_acc[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    // sweep the settings between idling phases, from the reset values to the extremes
    write_reg(CFG_GRAV, GRAV_RESET);
    write_reg(CFG_SOFT, 32'd0);
    write_reg(CFG_UNITM, 32'd0);
    test_random(375, 0, 0);
    write_reg(CFG_SOFT, 32'h0000_4000);
    write_reg(CFG_UNITM, 32'd1);
    test_random(375, 80, 0);
    write_reg(CFG_GRAV, 32'h0000_0100);
    write_reg(CFG_SOFT, 32'h0100_0000);
    test_random(375, 0, 80);
    write_reg(CFG_GRAV, 32'hFFFF_FFFF);
    write_reg(CFG_SOFT, 32'hFFFF_FFFF);
    write_reg(CFG_UNITM, 32'd0);
    test_random(375, 30, 30);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stall the result side at random; hold pop low during reset.
  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
  end

  // Compare each popped word with the oldest expected sum.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_acc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        if (out_data.acc_x !== pending_acc[0].acc_x || out_data.acc_y !== pending_acc[0].acc_y
            || out_data.acc_z !== pending_acc[0].acc_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("acc mismatch: expected x %h y %h z %h, got x %h y %h z %h",
                     pending_acc[0].acc_x, pending_acc[0].acc_y, pending_acc[0].acc_z,
                     out_data.acc_x, out_data.acc_y, out_data.acc_z);
          end
        end
        void'(pending_acc.pop_front());
      end
    end
  end

  // Hang detection: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// File: files.f
+incdir+sv
sv/sga_pkg.sv
sv/sga_front.sv
sv/sga_queue.sv
sv/sga_back.sv
sv/softened_gravity_accumulator.sv
test/tb_softened_gravity_accumulator.sv
